// File: hdl/ppvc_pkg.sv
// Shared types and constants for the point projection visibility cull core.
// No dependencies; used by every module of the block.
`default_nettype none

package ppvc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int POSE_DEPTH     = 12;
  localparam int QUEUE_DEPTH    = 4;

  // configuration register indexes
  localparam logic [2:0] REG_FOCAL_X     = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y     = 3'd1;
  localparam logic [2:0] REG_CENTER_X    = 3'd2;
  localparam logic [2:0] REG_CENTER_Y    = 3'd3;
  localparam logic [2:0] REG_IMAGE_COLS  = 3'd4;
  localparam logic [2:0] REG_IMAGE_ROWS  = 3'd5;
  localparam logic [2:0] REG_DEPTH_LIMIT = 3'd6;
  localparam logic [2:0] REG_SAMPLE_CAP  = 3'd7;

  typedef struct packed {
    logic [31:0] focal_x;
    logic [31:0] focal_y;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [12:0] image_columns;
    logic [12:0] image_rows;
    logic [30:0] depth_limit;
    logic [15:0] sample_cap;
  } cfg_t;

  // one queued transaction
  typedef struct packed {
    logic        is_point;
    logic [3:0]  word_index;
    logic [31:0] word_value;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [31:0] point_index;
    logic        last_point;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

endpackage

`default_nettype wire

// File: hdl/ppvc_front.sv
// Front end: accepts input transactions, classifies them, pushes to the queue.
// Depends on ppvc_pkg.
`default_nettype none

module ppvc_front (
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 action,
  input  wire logic [3:0]           word_index,
  input  wire logic signed [31:0]   word_value,
  input  wire logic signed [31:0]   point_x,
  input  wire logic signed [31:0]   point_y,
  input  wire logic signed [31:0]   point_z,
  input  wire logic [31:0]          point_index,
  input  wire logic                 last_point,
  input  wire logic                 q_full,
  output ppvc_pkg::push_t           wr
);

  logic load_ok;

  // loads to words past the matrix are taken and dropped here
  assign load_ok  = word_index < 4'(ppvc_pkg::POSE_DEPTH);
  assign in_stall = q_full;

  always_comb begin
    wr.push             = in_valid && !q_full && (action || load_ok);
    wr.item.is_point    = action;
    wr.item.word_index  = word_index;
    wr.item.word_value  = word_value;
    wr.item.point_x     = point_x;
    wr.item.point_y     = point_y;
    wr.item.point_z     = point_z;
    wr.item.point_index = point_index;
    wr.item.last_point  = last_point;
  end

endmodule

`default_nettype wire

// File: hdl/ppvc_queue.sv
// Short FIFO between front and back ends.
// Depends on ppvc_pkg.
`default_nettype none

module ppvc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ppvc_pkg::push_t wr,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output ppvc_pkg::item_t      head
);

  localparam int PW = $clog2(ppvc_pkg::QUEUE_DEPTH);

  ppvc_pkg::item_t entries [ppvc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = count == (PW+1)'(ppvc_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign head    = entries[rd_ptr];
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/ppvc_back.sv
// Back end: pose store, shared multiplier sequencer, frustum tests, cap counter
// and output register. Depends on ppvc_pkg.
`default_nettype none

module ppvc_back #(
  parameter int FRAC_BITS  = ppvc_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = ppvc_pkg::COUNT_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ppvc_pkg::cfg_t  cfg,
  input  wire logic            q_empty,
  input  wire ppvc_pkg::item_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 visible,
  output logic [31:0]          index_out,
  output logic                 frame_end
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [3:0]  STEP_LAST = 4'd14;
  localparam logic [31:0] NEAR_RAW  = 32'((64'd1 << FRAC_BITS) / 1000);
  localparam int          CMPW      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  logic [1:0]  state;
  logic [3:0]  step;
  logic [31:0] pose [ppvc_pkg::POSE_DEPTH];

  logic signed [65:0] acc;
  logic signed [65:0] prod;
  logic signed [65:0] sx;
  logic signed [65:0] sy;
  logic signed [65:0] kx;
  logic signed [65:0] ky;
  logic [31:0] cam_x;
  logic [31:0] cam_y;
  logic [31:0] cam_z;
  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] pz;
  logic [31:0] pidx;
  logic        plast;
  logic [COUNT_BITS-1:0] count;

  logic [3:0]  mul_addr;
  logic [3:0]  trans_addr;
  logic [3:0]  rd_addr;
  logic [31:0] pose_rd;
  logic [1:0]  coord_sel;
  logic        use_pose;
  logic        first;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [32:0] opnd_a;
  logic signed [32:0] opnd_b;
  logic signed [65:0] acc_sum;
  logic signed [65:0] cam_full;
  logic [31:0] cam_sat;
  logic [13:0] lim_x;
  logic [13:0] lim_y;
  logic        ok;
  logic        out_free;

  assign lim_x = {cfg.image_columns, 1'b0} - 14'd1;
  assign lim_y = {cfg.image_rows, 1'b0} - 14'd1;

  // operand schedule of the shared multiplier
  always_comb begin
    mul_addr   = 4'd0;
    trans_addr = 4'd0;
    coord_sel  = 2'd0;
    use_pose   = 1'b0;
    first      = 1'b0;
    opnd_a     = '0;
    opnd_b     = '0;
    unique case (step)
      4'd0:  begin mul_addr = 4'd0;  coord_sel = 2'd0; use_pose = 1'b1; first = 1'b1; end
      4'd1:  begin mul_addr = 4'd1;  coord_sel = 2'd1; use_pose = 1'b1; end
      4'd2:  begin mul_addr = 4'd2;  coord_sel = 2'd2; use_pose = 1'b1; trans_addr = 4'd3; end
      4'd3:  begin mul_addr = 4'd4;  coord_sel = 2'd0; use_pose = 1'b1; first = 1'b1; end
      4'd4:  begin mul_addr = 4'd5;  coord_sel = 2'd1; use_pose = 1'b1; end
      4'd5:  begin mul_addr = 4'd6;  coord_sel = 2'd2; use_pose = 1'b1; trans_addr = 4'd7; end
      4'd6:  begin mul_addr = 4'd8;  coord_sel = 2'd0; use_pose = 1'b1; first = 1'b1; end
      4'd7:  begin mul_addr = 4'd9;  coord_sel = 2'd1; use_pose = 1'b1; end
      4'd8:  begin mul_addr = 4'd10; coord_sel = 2'd2; use_pose = 1'b1; trans_addr = 4'd11; end
      4'd9:  begin
        opnd_a = {1'b0, cfg.focal_x};  opnd_b = {cam_x[31], cam_x}; first = 1'b1;
      end
      4'd10: begin opnd_a = {1'b0, cfg.center_x}; opnd_b = {cam_z[31], cam_z}; end
      4'd11: begin
        opnd_a = {1'b0, cfg.focal_y};  opnd_b = {cam_y[31], cam_y}; first = 1'b1;
      end
      4'd12: begin opnd_a = {1'b0, cfg.center_y}; opnd_b = {cam_z[31], cam_z}; end
      4'd13: begin opnd_a = {19'd0, lim_x}; opnd_b = {cam_z[31], cam_z}; end
      4'd14: begin opnd_a = {19'd0, lim_y}; opnd_b = {cam_z[31], cam_z}; end
      default: begin end
    endcase
  end

  assign rd_addr = (state == ST_ACC) ? trans_addr : mul_addr;
  assign pose_rd = pose[rd_addr];

  always_comb begin
    mul_a = opnd_a;
    mul_b = opnd_b;
    if (use_pose) begin
      mul_a = {pose_rd[31], pose_rd};
      case (coord_sel)
        2'd0:    mul_b = {px[31], px};
        2'd1:    mul_b = {py[31], py};
        default: mul_b = {pz[31], pz};
      endcase
    end
  end

  // exact row sum, floored to whole Q units, translated and saturated
  assign acc_sum  = (first ? 66'sd0 : acc) + prod;
  assign cam_full = (acc_sum >>> FRAC_BITS) + $signed({{34{pose_rd[31]}}, pose_rd});
  always_comb begin
    if (cam_full > SAT_HI) begin
      cam_sat = 32'h7FFF_FFFF;
    end else if (cam_full < SAT_LO) begin
      cam_sat = 32'h8000_0000;
    end else begin
      cam_sat = cam_full[31:0];
    end
  end

  // round-half-even(s / (z << F)) < lim, with k = z * (2 lim - 1)
  function automatic logic lands_inside(input logic signed [65:0] s,
                                        input logic signed [65:0] k,
                                        input logic [30:0] z,
                                        input logic [12:0] lim);
    logic signed [71:0] two_s;
    logic signed [71:0] bound;
    logic signed [71:0] dz;
    logic               res;
    two_s = {{5{s[65]}}, s, 1'b0};
    bound = {{6{k[65]}}, k} <<< FRAC_BITS;
    dz    = {41'd0, z} <<< FRAC_BITS;
    if (lim == 13'd0) begin
      res = 1'b0;
    end else if (!s[65]) begin
      res = (two_s < bound) || ((two_s == bound) && lim[0]);
    end else begin
      res = (-two_s) <= dz;
    end
    return res;
  endfunction

  always_comb begin
    ok = !cam_z[31] && (cam_z[30:0] > NEAR_RAW[30:0]);
    if (cfg.depth_limit != 31'd0 && !(cam_z[30:0] < cfg.depth_limit)) begin
      ok = 1'b0;
    end
    if (!lands_inside(sx, kx, cam_z[30:0], cfg.image_columns)) begin
      ok = 1'b0;
    end
    if (!lands_inside(sy, ky, cam_z[30:0], cfg.image_rows)) begin
      ok = 1'b0;
    end
    if (cfg.sample_cap != 16'd0 && CMPW'(count) >= CMPW'(cfg.sample_cap)) begin
      ok = 1'b0;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && !q_empty;

  // pose store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppvc_pkg::POSE_DEPTH; i++) begin
        pose[i] <= '0;
      end
    end else if (pop && !head.is_point) begin
      pose[head.word_index] <= head.word_value;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop && head.is_point) begin
      px    <= head.point_x;
      py    <= head.point_y;
      pz    <= head.point_z;
      pidx  <= head.point_index;
      plast <= head.last_point;
    end
    if (state == ST_MUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_ACC) begin
      acc <= acc_sum;
      case (step)
        4'd2:  cam_x <= cam_sat;
        4'd5:  cam_y <= cam_sat;
        4'd8:  cam_z <= cam_sat;
        4'd10: sx    <= acc_sum;
        4'd12: sy    <= acc_sum;
        4'd13: kx    <= prod;
        4'd14: ky    <= prod;
        default: begin end
      endcase
    end
    if (state == ST_FIN && out_free) begin
      visible   <= ok;
      index_out <= pidx;
      frame_end <= plast;
    end
  end

  // sequencer, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop && head.is_point) begin
            step  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          step  <= step + 4'd1;
          state <= (step == STEP_LAST) ? ST_FIN : ST_MUL;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (plast) begin
              count <= '0;
            end else if (ok && count != '1) begin
              count <= count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/point_projection_visibility_cull_core.sv
// Point projection visibility cull: top level with configuration registers.
// Depends on ppvc_pkg, ppvc_front, ppvc_queue and ppvc_back.
//
// Usage notes
// - Input channel (in_valid / in_stall): one transaction per item. action 0
//   loads word word_index of the 3x4 world-to-camera pose, action 1 tests a
//   point. Loads to words above eleven are taken and discarded.
// - Output channel (out_valid / out_stall): one transaction per point with the
//   visible flag, the point index and the frame-end mark. Loads give none.
// - Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
// - A four-entry queue separates the front end from the back end, so input is
//   taken while the back end works or a result waits on a stalled receiver.
// - Back end: a load is written to the pose store on dequeue. A point runs
//   through the single shared 33x33 multiplier: fifteen multiplies (nine for
//   the pose, four for projection, two for the image bounds), each a multiply
//   state and an accumulate state, plus dequeue and final test; the back end
//   dequeues no new item until the point's result is registered.
// - Out_stall holds the result in the output register; the back end waits at
//   its final test until that register frees, then the queue fills and
//   in_stall rises.
// - Reset (rst, synchronous): clears configuration, pose, the visible counter,
//   the queue and the output valid.
`default_nettype none

module point_projection_visibility_cull_core #(
  parameter int FRAC_BITS  = ppvc_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = ppvc_pkg::COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic [3:0]         word_index,
  input  wire logic signed [31:0] word_value,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic [31:0]        point_index,
  input  wire logic               last_point,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    visible,
  output logic [31:0]             index_out,
  output logic                    frame_end,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  ppvc_pkg::cfg_t  cfg;
  ppvc_pkg::push_t wr;
  ppvc_pkg::item_t head;
  logic            q_full;
  logic            q_empty;
  logic            pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ppvc_pkg::REG_FOCAL_X:     cfg.focal_x       <= cfg_data;
        ppvc_pkg::REG_FOCAL_Y:     cfg.focal_y       <= cfg_data;
        ppvc_pkg::REG_CENTER_X:    cfg.center_x      <= cfg_data;
        ppvc_pkg::REG_CENTER_Y:    cfg.center_y      <= cfg_data;
        ppvc_pkg::REG_IMAGE_COLS:  cfg.image_columns <= cfg_data[12:0];
        ppvc_pkg::REG_IMAGE_ROWS:  cfg.image_rows    <= cfg_data[12:0];
        ppvc_pkg::REG_DEPTH_LIMIT: cfg.depth_limit   <= cfg_data[30:0];
        ppvc_pkg::REG_SAMPLE_CAP:  cfg.sample_cap    <= cfg_data[15:0];
        default: begin end
      endcase
    end
  end

  ppvc_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .word_index  (word_index),
    .word_value  (word_value),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_index (point_index),
    .last_point  (last_point),
    .q_full      (q_full),
    .wr          (wr)
  );

  ppvc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (head)
  );

  ppvc_back #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .visible   (visible),
    .index_out (index_out),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for point_projection_visibility_cull_core.
// Depends on ppvc_pkg and the core; predicts visibility per point, checks every result.
`timescale 1ns / 100ps

module tb_top;

  localparam int       LIMIT_CYCLES = 400000;
  localparam int       DRAIN_CYCLES = 40;
  localparam int       HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam bit       ACT_LOAD     = 1'b0;
  localparam bit       ACT_POINT    = 1'b1;
  localparam int       ONE          = 1 << 16;
  localparam int       NEAR_Z       = 65;   // 1e-3 in Q16.16, floored
  localparam bit [15:0] COUNT_TOP   = 16'hFFFF;

  typedef struct {
    bit        action;
    bit [3:0]  widx;
    bit [31:0] wval;
    bit [31:0] px, py, pz;
    bit [31:0] pidx;
    bit        last;
    bit        typed;   // expected visibility written into the table
    bit        exp_vis;
  } stim_t;

  typedef struct {
    bit        vis;
    bit [31:0] idx;
    bit        fend;
  } cull_res_t;

  logic clk, rst;
  logic in_valid, in_stall, action, last_point;
  logic [3:0] word_index;
  logic signed [31:0] word_value, point_x, point_y, point_z;
  logic [31:0] point_index;
  logic out_valid, out_stall, visible, frame_end;
  logic [31:0] index_out;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  point_projection_visibility_cull_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .word_index(word_index), .word_value(word_value),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .point_index(point_index), .last_point(last_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .visible(visible), .index_out(index_out), .frame_end(frame_end),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the core's state and registers
  logic signed [31:0] pose_w [ppvc_pkg::POSE_DEPTH];
  bit [15:0]      vis_count;
  ppvc_pkg::cfg_t shadow_cfg;

  cull_res_t pending_q[$];
  int        errors;
  int        cycles;
  int        send_idle, recv_idle;  // idle percentages per cycle
  bit        hold_req;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One camera axis: floor(row . p / 2^16) + translation, saturated to 32 bits.
  function automatic logic signed [31:0] cam_axis(int r, logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
    logic signed [79:0] acc, m, q;
    logic signed [31:0] p [3];
    p[0] = px; p[1] = py; p[2] = pz;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      m = pose_w[r*4+c];
      q = p[c];
      acc += m * q;
    end
    acc = acc >>> 16;
    m = pose_w[r*4+3];
    acc += m;
    if (acc > 80'sd2147483647) return 32'sh7FFFFFFF;
    if (acc < -80'sd2147483648) return 32'sh80000000;
    return acc[31:0];
  endfunction

  function automatic logic [95:0] div_even(logic [95:0] n, logic [95:0] d);
    logic [95:0] q, r;
    q = n / d;
    r = n % d;
    if (2*r > d) return q + 1;
    if (2*r < d) return q;
    return q + q[0];
  endfunction

  // Does the rounded projection fall in [0, lim)?  z is positive here.
  function automatic bit on_sensor(logic [31:0] focal, logic [31:0] centre,
                                   logic signed [31:0] coord, logic signed [31:0] z,
                                   logic [12:0] lim);
    logic [95:0] d, mag, prod, cz;
    logic signed [32:0] cs;
    cs   = coord;
    mag  = (cs < 0) ? -cs : cs;
    d    = {64'd0, z} << 16;
    prod = {64'd0, focal} * mag;
    cz   = {64'd0, centre} * {64'd0, z};
    if (cs >= 0) return div_even(prod + cz, d) < lim;
    if (prod <= cz) return div_even(cz - prod, d) < lim;
    // negative side: only a value rounding to zero survives
    return div_even(prod - cz, d) == 0 && lim != 0;
  endfunction

  // Applies one accepted transaction to the shadow state; returns 1 for a point.
  function automatic bit cull_predict(stim_t it, output cull_res_t res);
    logic signed [31:0] cxv, cyv, czv;
    bit ok;
    res = '{default: 0};
    if (it.action == ACT_LOAD) begin
      if (it.widx < ppvc_pkg::POSE_DEPTH) pose_w[it.widx] = it.wval;
      return 0;
    end
    cxv = cam_axis(0, it.px, it.py, it.pz);
    cyv = cam_axis(1, it.px, it.py, it.pz);
    czv = cam_axis(2, it.px, it.py, it.pz);
    ok = czv > NEAR_Z;
    if (ok && shadow_cfg.depth_limit != 0 &&
        !(longint'(czv) < longint'(shadow_cfg.depth_limit)))
      ok = 0;
    if (ok && !on_sensor(shadow_cfg.focal_x, shadow_cfg.center_x, cxv, czv,
                         shadow_cfg.image_columns))
      ok = 0;
    if (ok && !on_sensor(shadow_cfg.focal_y, shadow_cfg.center_y, cyv, czv,
                         shadow_cfg.image_rows))
      ok = 0;
    if (ok && shadow_cfg.sample_cap != 0 && vis_count >= shadow_cfg.sample_cap) ok = 0;
    if (ok && vis_count != COUNT_TOP) vis_count++;
    if (it.last) vis_count = 0;
    res.vis  = ok;
    res.idx  = it.pidx;
    res.fend = it.last;
    return 1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_t ld(int idx, bit [31:0] val);
    stim_t s = '{default: 0};
    s.action = ACT_LOAD;
    s.widx   = 4'(idx);
    s.wval   = val;
    s.last   = 1'($urandom_range(1));  // ignored on loads
    return s;
  endfunction

  function automatic stim_t pt(bit [31:0] x, bit [31:0] y, bit [31:0] z,
                               bit [31:0] idx, bit last, bit typed = 0, bit ev = 0);
    stim_t s = '{default: 0};
    s.action  = ACT_POINT;
    s.px = x; s.py = y; s.pz = z;
    s.pidx    = idx;
    s.last    = last;
    s.typed   = typed;
    s.exp_vis = ev;
    return s;
  endfunction

  // Sender side of the input channel; prediction happens on acceptance.
  task automatic send(stim_t it);
    cull_res_t res;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= it.action;
    word_index  <= it.widx;
    word_value  <= it.wval;
    point_x     <= it.px;
    point_y     <= it.py;
    point_z     <= it.pz;
    point_index <= it.pidx;
    last_point  <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cull_predict(it, res)) begin
      if (it.typed) res.vis = it.exp_vis;
      pending_q.push_back(res);
    end
  endtask

  // Waits out every pending result plus the core's latency.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      ppvc_pkg::REG_FOCAL_X:     shadow_cfg.focal_x       = val;
      ppvc_pkg::REG_FOCAL_Y:     shadow_cfg.focal_y       = val;
      ppvc_pkg::REG_CENTER_X:    shadow_cfg.center_x      = val;
      ppvc_pkg::REG_CENTER_Y:    shadow_cfg.center_y      = val;
      ppvc_pkg::REG_IMAGE_COLS:  shadow_cfg.image_columns = val[12:0];
      ppvc_pkg::REG_IMAGE_ROWS:  shadow_cfg.image_rows    = val[12:0];
      ppvc_pkg::REG_DEPTH_LIMIT: shadow_cfg.depth_limit   = val[30:0];
      ppvc_pkg::REG_SAMPLE_CAP:  shadow_cfg.sample_cap    = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(ppvc_pkg::cfg_t c);
    write_reg(ppvc_pkg::REG_FOCAL_X, c.focal_x);
    write_reg(ppvc_pkg::REG_FOCAL_Y, c.focal_y);
    write_reg(ppvc_pkg::REG_CENTER_X, c.center_x);
    write_reg(ppvc_pkg::REG_CENTER_Y, c.center_y);
    write_reg(ppvc_pkg::REG_IMAGE_COLS, 32'(c.image_columns));
    write_reg(ppvc_pkg::REG_IMAGE_ROWS, 32'(c.image_rows));
    write_reg(ppvc_pkg::REG_DEPTH_LIMIT, 32'(c.depth_limit));
    write_reg(ppvc_pkg::REG_SAMPLE_CAP, 32'(c.sample_cap));
  endtask

  // A near-identity pose with small random skew and a random shift.
  task automatic load_pose();
    int v;
    for (int w = 0; w < ppvc_pkg::POSE_DEPTH; w++) begin
      if (w == 0 || w == 5 || w == 10) v = ONE;
      else if (w % 4 == 3) v = int'($urandom_range(4*ONE)) - 2*ONE;
      else v = int'($urandom_range(ONE/10)) - ONE/20;
      send(ld(w, v));
    end
  endtask

  // Mostly points that sit in front of the camera near the view cone;
  // the rest is raw noise and stray loads, some to unused words.
  function automatic stim_t rand_item();
    int r, zr, x, y;
    r = $urandom_range(99);
    if (r < 4) return ld($urandom_range(15), $urandom);
    if (r < 14)
      return pt($urandom, $urandom, $urandom, $urandom, $urandom_range(7) == 0);
    zr = $urandom_range(50*ONE, ONE/100);
    x  = int'($urandom_range(2*zr)) - zr;
    y  = int'($urandom_range(2*zr)) - zr;
    return pt(x, y, zr, $urandom, $urandom_range(7) == 0);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, receiver, result checker, watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Each result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    cull_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: index_out %h", index_out);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (visible !== want.vis) begin
          $error("visible: expected %0d, got %0d", want.vis, visible);
          errors++;
        end
        if (index_out !== want.idx) begin
          $error("index_out: expected %h, got %h", want.idx, index_out);
          errors++;
        end
        if (frame_end !== want.fend) begin
          $error("frame_end: expected %0d, got %0d", want.fend, frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  stim_t          reset_tab[$];
  stim_t          dir_tab[$];
  ppvc_pkg::cfg_t phase_cfg[5];

  initial begin
    errors    = 0;
    cycles    = 0;
    hold_req  = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    action      <= ACT_LOAD;
    word_index  <= '0;
    word_value  <= '0;
    point_x     <= '0;
    point_y     <= '0;
    point_z     <= '0;
    point_index <= '0;
    last_point  <= 1'b0;
    cfg_write   <= 1'b0;
    cfg_index   <= ppvc_pkg::REG_FOCAL_X;
    cfg_data    <= '0;
    foreach (pose_w[i]) pose_w[i] = '0;
    vis_count  = '0;
    shadow_cfg = '0;

    // registers still at reset: zero image size, nothing visible
    reset_tab = '{
      pt(0, 0, 10*ONE, 0, 0, 1, 0),
      pt(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1, 1, 0),
      ld(1, 32'h80000000), ld(2, 32'h7FFFFFFF),
      ld(1, 0), ld(2, 0),
      ld(0, ONE), ld(5, ONE), ld(10, ONE),
      ld(12, 32'hDEADBEEF), ld(15, 32'hFFFFFFFF)   // unused words, dropped
    };
    // 640x480 camera, identity pose
    dir_tab = '{
      pt(0, 0, 10*ONE, 1, 0),
      pt(0, 0, 0, 2, 0, 1, 0),                 // on the camera plane
      pt(0, 0, -ONE, 3, 0, 1, 0),              // behind the camera
      pt(0, 0, NEAR_Z, 4, 0, 1, 0),            // exactly at the near cut
      pt(0, 0, NEAR_Z + 1, 5, 0),
      pt(-41943, 0, ONE, 6, 0),                // left edge, rounds to 0
      pt(-41944, 0, ONE, 7, 0),                // just left, rounds to 0
      pt(41943, 0, ONE, 8, 0),                 // right edge, rounds to 640
      pt(0, -31457, ONE, 9, 0),
      pt(0, 31457, ONE, 10, 0),
      pt(32'h80000000, 32'h80000000, ONE, 11, 0),
      pt(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 1)
    };

    phase_cfg[0] = '{500*ONE, 500*ONE, 320*ONE, 240*ONE, 13'd640, 13'd480, 31'd0, 16'd0};
    phase_cfg[1] = '{500*ONE, 500*ONE, 320*ONE, 240*ONE, 13'd640, 13'd480,
                     31'(30*ONE), 16'd3};
    phase_cfg[2] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                     13'h1FFF, 13'h1FFF, 31'h7FFFFFFF, 16'hFFFF};
    phase_cfg[3] = '{$urandom_range(2000*ONE), $urandom_range(2000*ONE),
                     $urandom_range(1000*ONE), $urandom_range(1000*ONE),
                     13'($urandom_range(8191)), 13'($urandom_range(8191)),
                     31'($urandom_range(100*ONE)), 16'd1};
    phase_cfg[4] = '{32'd0, 32'd0, 32'd0, 32'd0, 13'd1, 13'd1, 31'd1, 16'd1};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_tab[i]) send(reset_tab[i]);
    drain();
    write_all(phase_cfg[0]);
    foreach (dir_tab[i]) send(dir_tab[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_all(phase_cfg[ph]);
      // sender mostly active and receiver mostly stalled, then the reverse, then flat out
      if (ph < 2) begin
        send_idle = 21; recv_idle = 78;
      end else if (ph < 4) begin
        send_idle = 78; recv_idle = 21;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      load_pose();
      if (ph == 1) hold_req = 1'b1;  // queue fills, in_stall must rise
      repeat (64) send(rand_item());
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
